>>> src/min_stk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_stk_pkg
// Shared sizes, codes and the result record for the running-minimum stack.
// ----------------------------------------------------------------------------
package min_stk_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int STATUS_W    = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] min_value;
      logic                     is_empty;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

endpackage

>>> src/stack_with_running_minimum_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_running_minimum_core
// LIFO stack of signed 32-bit values that reports its minimum with every
// response. A pop passes through a fetch state, since the new top of the
// main and minimum stacks is fetched from the stack RAMs, which register
// their read data; a push does not. Push-on-full and pop-on-empty change
// nothing and return a status code. The tops of both stacks are held in
// registers, entries below them live in two RAMs of STACK_DEPTH words. A
// two-entry response queue lets the next request in while a response waits.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stack_with_running_minimum_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_op,
   input  logic signed [min_stk_pkg::DATA_W-1:0]   req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [min_stk_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic signed [min_stk_pkg::DATA_W-1:0]   rsp_top_value,
   output logic signed [min_stk_pkg::DATA_W-1:0]   rsp_min_value,
   output logic                                    rsp_is_empty,
   output logic [min_stk_pkg::STATUS_W-1:0]        rsp_status
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_FETCH = 1'b1;

   localparam int DATA_W = min_stk_pkg::DATA_W;
   localparam int ADDR_W = min_stk_pkg::ADDR_W;
   localparam int CNT_W  = min_stk_pkg::CNT_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(min_stk_pkg::STACK_DEPTH);

   logic                     state_ff;
   logic                     state_in;
   logic [CNT_W-1:0]         main_cnt_ff;
   logic [CNT_W-1:0]         main_cnt_in;
   logic [CNT_W-1:0]         min_cnt_ff;
   logic [CNT_W-1:0]         min_cnt_in;
   logic signed [DATA_W-1:0] main_top_ff;
   logic signed [DATA_W-1:0] main_top_in;
   logic signed [DATA_W-1:0] min_top_ff;
   logic signed [DATA_W-1:0] min_top_in;
   logic signed [DATA_W-1:0] pop_val_ff;
   logic signed [DATA_W-1:0] pop_val_in;

   logic                     req_fire;
   logic                     main_empty;
   logic                     main_full;
   logic                     take_min;
   logic                     min_room;
   logic                     main_wr;
   logic                     min_wr;
   logic                     rd_en;
   logic [ADDR_W-1:0]        main_rd_addr;
   logic [ADDR_W-1:0]        min_rd_addr;
   logic [DATA_W-1:0]        main_rd_data;
   logic [DATA_W-1:0]        min_rd_data;
   logic                     q_wr;
   logic                     q_full;
   min_stk_pkg::rsp_type     q_wr_data;
   min_stk_pkg::rsp_type     q_rd_data;

   assign req_stall  = (state_ff != ST_IDLE) || q_full;
   assign req_fire   = req_valid && !req_stall;
   assign main_empty = (main_cnt_ff == '0);
   assign main_full  = (main_cnt_ff == FULL_CNT);
   assign min_room   = (min_cnt_ff != FULL_CNT);
   assign take_min   = main_empty || (min_cnt_ff == '0) || (req_value <= min_top_ff);

   // entry below the current main top, and the minimum-stack top left after the pop
   assign main_rd_addr = ADDR_W'(main_cnt_ff - CNT_W'(2));
   assign min_rd_addr  = ADDR_W'(min_cnt_in - CNT_W'(1));

   always_comb begin
      state_in    = state_ff;
      main_cnt_in = main_cnt_ff;
      min_cnt_in  = min_cnt_ff;
      main_top_in = main_top_ff;
      min_top_in  = min_top_ff;
      pop_val_in  = pop_val_ff;
      main_wr     = 1'b0;
      min_wr      = 1'b0;
      rd_en       = 1'b0;
      q_wr        = 1'b0;
      q_wr_data   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == min_stk_pkg::OP_PUSH) begin
                  q_wr = 1'b1;
                  if (main_full) begin
                     q_wr_data.top_value = main_top_ff;
                     q_wr_data.min_value = (min_cnt_ff != '0) ? min_top_ff : '0;
                     q_wr_data.status    = min_stk_pkg::STATUS_PUSH_FULL;
                  end else begin
                     main_wr     = 1'b1;
                     main_cnt_in = main_cnt_ff + CNT_W'(1);
                     main_top_in = req_value;
                     if (take_min && min_room) begin
                        min_wr     = 1'b1;
                        min_cnt_in = min_cnt_ff + CNT_W'(1);
                        min_top_in = req_value;
                     end
                     q_wr_data.top_value = req_value;
                     q_wr_data.min_value = (min_cnt_in != '0) ? min_top_in : '0;
                     q_wr_data.status    = min_stk_pkg::STATUS_OK;
                  end
               end else begin
                  if (main_empty) begin
                     q_wr               = 1'b1;
                     q_wr_data.is_empty = 1'b1;
                     q_wr_data.status   = min_stk_pkg::STATUS_POP_EMPTY;
                  end else begin
                     main_cnt_in = main_cnt_ff - CNT_W'(1);
                     if ((min_cnt_ff != '0) && (min_top_ff == main_top_ff)) begin
                        min_cnt_in = min_cnt_ff - CNT_W'(1);
                     end
                     pop_val_in = main_top_ff;
                     rd_en      = 1'b1;
                     state_in   = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            // queue space was reserved when the pop was taken
            q_wr                   = 1'b1;
            main_top_in            = main_rd_data;
            min_top_in             = min_rd_data;
            q_wr_data.popped_value = pop_val_ff;
            q_wr_data.top_value    = (main_cnt_ff != '0) ? main_rd_data : '0;
            q_wr_data.min_value    = ((min_cnt_ff != '0) && (main_cnt_ff != '0)) ?
                                     min_rd_data : '0;
            q_wr_data.is_empty     = (main_cnt_ff == '0);
            q_wr_data.status       = min_stk_pkg::STATUS_OK;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         main_cnt_ff <= '0;
         min_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         main_cnt_ff <= main_cnt_in;
         min_cnt_ff  <= min_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      main_top_ff <= main_top_in;
      min_top_ff  <= min_top_in;
      pop_val_ff  <= pop_val_in;
   end

   min_stk_ram #(
      .DATA_W (DATA_W),
      .DEPTH  (min_stk_pkg::STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_main_ram (
      .clock   (clock),
      .wr_en   (main_wr),
      .wr_addr (main_cnt_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (main_rd_addr),
      .rd_data (main_rd_data)
   );

   min_stk_ram #(
      .DATA_W (DATA_W),
      .DEPTH  (min_stk_pkg::STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_min_ram (
      .clock   (clock),
      .wr_en   (min_wr),
      .wr_addr (min_cnt_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (min_rd_addr),
      .rd_data (min_rd_data)
   );

   min_stk_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push_en   (q_wr),
      .push_data (q_wr_data),
      .full      (q_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (q_rd_data)
   );

   assign rsp_popped_value = q_rd_data.popped_value;
   assign rsp_top_value    = q_rd_data.top_value;
   assign rsp_min_value    = q_rd_data.min_value;
   assign rsp_is_empty     = q_rd_data.is_empty;
   assign rsp_status       = q_rd_data.status;

   a_min_le_main: assert property (@(posedge clock) disable iff (reset)
      min_cnt_ff <= main_cnt_ff)
      else $error("minimum stack deeper than main stack");

   a_min_nonempty: assert property (@(posedge clock) disable iff (reset)
      (main_cnt_ff != '0) |-> (min_cnt_ff != '0))
      else $error("main stack holds entries but minimum stack is empty");

   a_fetch_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_IDLE))
      else $error("fetch lasted more than one cycle");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == min_stk_pkg::OP_PUSH) && !main_full)
      |=> (main_cnt_ff == $past(main_cnt_ff) + CNT_W'(1)))
      else $error("push did not advance the main count");

endmodule

>>> src/min_stk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_stk_ram
// Single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module min_stk_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/min_stk_rsp_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_stk_rsp_q
// Two-entry response queue; lets a new request in while a response waits.
// ----------------------------------------------------------------------------
module min_stk_rsp_q (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_en,
   input  min_stk_pkg::rsp_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output min_stk_pkg::rsp_type out_data
);

   min_stk_pkg::rsp_type ent_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop_en;

   assign pop_en    = out_valid && !out_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign full      = (cnt_ff == 2'd2);
   assign out_data  = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_en ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_en && !pop_en) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_en && !push_en) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_en |-> !full)
      else $error("response queue written while full");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("response queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("response queue pointers disagree with count");

endmodule

>>> tb/sv/stack_with_running_minimum_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_running_minimum_core_test
// Self-checking bench for the running-minimum stack. A scoreboard keeps its
// own copy of both stacks and predicts each response when a request is taken.
// Directed requests cover the extremes, duplicate minima and pop-on-empty.
// Random segments then fill, drain and churn the stack while both sides idle
// at random, with one long stretch where neither side idles.
// ----------------------------------------------------------------------------
module stack_with_running_minimum_core_test;

   localparam int DATA_W      = min_stk_pkg::DATA_W;
   localparam int STACK_DEPTH = min_stk_pkg::STACK_DEPTH;
   localparam int STATUS_W    = min_stk_pkg::STATUS_W;

   typedef min_stk_pkg::rsp_type rsp_type;

   localparam int RANDOM_ITEMS  = 1630;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT   = 40;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   class min_stack_scoreboard;
      logic signed [DATA_W-1:0] main_copy[STACK_DEPTH];
      logic signed [DATA_W-1:0] min_copy[STACK_DEPTH];
      int main_depth;
      int min_depth;
      rsp_type expected_results[$];
      int failures;

      function new();
         main_depth = 0;
         min_depth  = 0;
         failures   = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // works out the response for a request taken by the block
      function void record_request(logic op, logic signed [DATA_W-1:0] value);
         rsp_type outcome;
         outcome = '0;
         outcome.status = min_stk_pkg::STATUS_OK;
         if (op == min_stk_pkg::OP_PUSH) begin
            if (main_depth >= STACK_DEPTH) begin
               outcome.status = min_stk_pkg::STATUS_PUSH_FULL;
            end else begin
               // equal values go on the min stack too, so duplicates survive pops
               if (main_depth == 0 || min_depth == 0 || value <= min_copy[min_depth-1]) begin
                  min_copy[min_depth] = value;
                  min_depth++;
               end
               main_copy[main_depth] = value;
               main_depth++;
            end
         end else begin
            if (main_depth == 0) begin
               outcome.status = min_stk_pkg::STATUS_POP_EMPTY;
            end else begin
               outcome.popped_value = main_copy[main_depth-1];
               if (min_depth > 0 && min_copy[min_depth-1] == outcome.popped_value)
                  min_depth--;
               main_depth--;
            end
         end
         if (main_depth > 0)
            outcome.top_value = main_copy[main_depth-1];
         if (main_depth > 0 && min_depth > 0)
            outcome.min_value = min_copy[min_depth-1];
         outcome.is_empty = (main_depth == 0);
         expected_results.push_back(outcome);
      endfunction

      function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         failures++;
         if (failures <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= PRINT_LIMIT)
               $display("%0t: response with none expected, expected nothing actual %0h",
                        $time, got);
            return;
         end
         want = expected_results.pop_front();
         if (got.popped_value !== want.popped_value)
            report("popped_value", want.popped_value, got.popped_value);
         if (got.top_value !== want.top_value)
            report("top_value", want.top_value, got.top_value);
         if (got.min_value !== want.min_value)
            report("min_value", want.min_value, got.min_value);
         if (got.is_empty !== want.is_empty)
            report("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
         if (got.status !== want.status)
            report("status", DATA_W'(want.status), DATA_W'(got.status));
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_op;
   logic signed [DATA_W-1:0]    req_value;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]    rsp_popped_value;
   logic signed [DATA_W-1:0]    rsp_top_value;
   logic signed [DATA_W-1:0]    rsp_min_value;
   logic                        rsp_is_empty;
   logic [STATUS_W-1:0]         rsp_status;

   min_stack_scoreboard sb;
   bit idle_enabled = 1'b1;
   int quiet_cycles = 0;

   stack_with_running_minimum_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_top_value    (rsp_top_value),
      .rsp_min_value    (rsp_min_value),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= idle_enabled && ($urandom_range(99) < 31);
   end

   // request is noted before the response check so a same-edge pair stays ordered
   always @(posedge clock) begin
      rsp_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.record_request(req_op, req_value);
         if (rsp_valid && !rsp_stall) begin
            got.popped_value = rsp_popped_value;
            got.top_value    = rsp_top_value;
            got.min_value    = rsp_min_value;
            got.is_empty     = rsp_is_empty;
            got.status       = rsp_status;
            sb.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(input logic op, input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      while (idle_enabled && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         req_op    <= 1'($urandom_range(1));
         req_value <= $urandom;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40)
         return $urandom;
      else if (roll < 75)
         return $signed($urandom_range(16)) - 8;
      else if (roll < 85) begin
         case ($urandom_range(3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            default: return -1;
         endcase
      end
      return $signed($urandom_range(2000)) - 1000;
   endfunction

   initial begin
      int issued;
      int seg_len;
      int push_pct;
      logic op;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = min_stk_pkg::OP_PUSH;
      req_value    = '0;
      idle_enabled = 1'b1;
      sb = new();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pop-on-empty, extremes, duplicate minima
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_PUSH, '0);
      send_request(min_stk_pkg::OP_PUSH, VAL_MAX);
      send_request(min_stk_pkg::OP_PUSH, VAL_MIN);
      send_request(min_stk_pkg::OP_PUSH, VAL_MIN);
      send_request(min_stk_pkg::OP_PUSH, -1);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_PUSH, 5);
      send_request(min_stk_pkg::OP_PUSH, 5);
      send_request(min_stk_pkg::OP_PUSH, 7);
      send_request(min_stk_pkg::OP_PUSH, 3);
      send_request(min_stk_pkg::OP_PUSH, 3);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);
      send_request(min_stk_pkg::OP_POP, $urandom);

      // random segments biased to fill, drain or churn the stack
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         seg_len = $urandom_range(120, 20);
         for (int i = 0; i < seg_len && issued < RANDOM_ITEMS; i++) begin
            idle_enabled = !(issued >= 500 && issued < 850);
            op = ($urandom_range(99) < push_pct) ? min_stk_pkg::OP_PUSH : min_stk_pkg::OP_POP;
            send_request(op, (op == min_stk_pkg::OP_PUSH) ? pick_value() : $urandom);
            issued++;
         end
      end
      idle_enabled = 1'b1;
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> stack_with_running_minimum_core.f
src/min_stk_pkg.sv
src/min_stk_ram.sv
src/min_stk_rsp_q.sv
src/stack_with_running_minimum_core.sv
tb/sv/stack_with_running_minimum_core_test.sv
